// ===== hw/rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the sbus frame receiver: item structs,
// request codes, sync bytes and the per-channel bit location table.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int FRAME_BYTES = 23;
  localparam int CH_BITS     = 11;
  localparam int BYTE_BITS   = 8;
  localparam int CH_COUNT    = 16;

  // frame bytes are spread over three rams by byte index mod 3
  localparam int RES_COUNT  = 3;
  localparam int SLOT_COUNT = 8;
  localparam int RES_W      = 2;
  localparam int SLOT_W     = 3;
  localparam int IDX_W      = 5;
  localparam int SHIFT_W    = 3;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_READ = 1'b1;

  localparam logic [BYTE_BITS-1:0] SYNC_PREV = 8'h00;
  localparam logic [BYTE_BITS-1:0] SYNC_HEAD = 8'h0F;

  typedef struct packed {
    logic                 req_type;
    logic [BYTE_BITS-1:0] rx_byte;
    logic [3:0]           channel_index;
  } in_item_t;

  typedef struct packed {
    logic [CH_BITS-1:0] channel_value;
    logic [3:0]         channel_echo;
  } out_item_t;

  // first frame byte of a channel, bit offset in it, and its ram residue and slot
  typedef struct packed {
    logic [IDX_W-1:0]   start;
    logic [SHIFT_W-1:0] shift;
    logic [RES_W-1:0]   res;
    logic [SLOT_W-1:0]  slot;
  } chan_loc_t;

  localparam chan_loc_t CHAN_LOC [CH_COUNT] = '{
    '{5'd1,  3'd0, 2'd1, 3'd0},
    '{5'd2,  3'd3, 2'd2, 3'd0},
    '{5'd3,  3'd6, 2'd0, 3'd1},
    '{5'd5,  3'd1, 2'd2, 3'd1},
    '{5'd6,  3'd4, 2'd0, 3'd2},
    '{5'd7,  3'd7, 2'd1, 3'd2},
    '{5'd9,  3'd2, 2'd0, 3'd3},
    '{5'd10, 3'd5, 2'd1, 3'd3},
    '{5'd12, 3'd0, 2'd0, 3'd4},
    '{5'd13, 3'd3, 2'd1, 3'd4},
    '{5'd14, 3'd6, 2'd2, 3'd4},
    '{5'd16, 3'd1, 2'd1, 3'd5},
    '{5'd17, 3'd4, 2'd2, 3'd5},
    '{5'd18, 3'd7, 2'd0, 3'd6},
    '{5'd20, 3'd2, 2'd2, 3'd6},
    '{5'd21, 3'd5, 2'd0, 3'd7}
  };

endpackage

// ===== hw/rtl/sfr_ram.sv =====
// ----------------------------------------------------------------------------
// sfr_ram
// Generic single-write, single-read synchronous ram with registered read data.
// ----------------------------------------------------------------------------
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ===== hw/rtl/sbus_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// sbus_frame_receiver_unit
// SBUS frame receiver: buffers serial bytes, latches a 23-byte frame on the
// 0x00 / 0x0F sync pair and returns 11-bit channel values from that frame.
// ----------------------------------------------------------------------------
// Takes one beat per clock, byte or channel read alike, while in_ready is high;
// a three-entry output queue keeps the input open while results wait, until it
// and the read stage hold three. A read passes the ram read register, then the
// output queue. Frame bytes 0..22 live in two banks of three rams each (byte
// index mod 3), so a channel's three bytes come from three different rams
// in one read cycle. Each byte position carries a receive-bank and a frame-bank
// select bit; a write never lands in the frame bank, and latching a frame is
// just copying the receive selects into the frame selects in the same cycle.
// Receive positions at or beyond byte 23 hold nothing that is ever read, so
// only the fill count tracks them. Per-entry valid bits make unwritten bytes
// read as zero after reset; no clearing pass is needed.
module sbus_frame_receiver_unit
  import sfr_pkg::*;
#(
  parameter int BUFFER_DEPTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int FILL_W   = $clog2(BUFFER_DEPTH + 1);
  localparam int NBANK    = 2;
  localparam int OQ_DEPTH = 3;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  // receive side state
  logic [FILL_W-1:0]                  fill_r, fill_nxt;
  logic [RES_W-1:0]                   wr_res_r, wr_res_nxt;
  logic [SLOT_W-1:0]                  wr_slot_r, wr_slot_nxt;
  logic [BYTE_BITS-1:0]               last_r, last_nxt;
  logic [FRAME_BYTES-1:0]             rx_sel_r, rx_sel_nxt;
  logic [FRAME_BYTES-1:0]             frame_sel_r, frame_sel_nxt;
  logic [NBANK-1:0][FRAME_BYTES-1:0]  vld_r, vld_nxt;

  logic              byte_beat;
  logic              rd_beat;
  logic [IDX_W-1:0]  wr_idx;
  logic              in_frame;
  logic              not_full;
  logic              wr_bank;
  logic              ram_we;
  logic              sync_hit;

  // read address side
  chan_loc_t         loc;
  logic [RES_W:0]    rsum  [RES_COUNT];
  logic [RES_W-1:0]  rd_res  [RES_COUNT];
  logic [SLOT_W-1:0] rd_kslot [RES_COUNT];
  logic [IDX_W-1:0]  rd_idx  [RES_COUNT];
  logic              rd_bank [RES_COUNT];
  logic              rd_zero [RES_COUNT];
  logic [SLOT_W-1:0] rd_slot [RES_COUNT];

  logic [BYTE_BITS-1:0] ram_rdata [NBANK][RES_COUNT];

  // read stage
  logic               s1_valid_r;
  logic [3:0]         s1_ch_r;
  logic [SHIFT_W-1:0] s1_shift_r;
  logic               s1_bank_r [RES_COUNT];
  logic [RES_W-1:0]   s1_res_r  [RES_COUNT];
  logic               s1_zero_r [RES_COUNT];

  logic [BYTE_BITS-1:0]             s1_byte [RES_COUNT];
  logic [RES_COUNT*BYTE_BITS-1:0]   s1_word;
  logic [RES_COUNT*BYTE_BITS-1:0]   s1_shifted;
  out_item_t                        s1_item;

  // output queue
  out_item_t             oq_mem_r [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   oq_head_r, oq_head_nxt;
  logic [OQ_PTR_W-1:0]   oq_tail_r, oq_tail_nxt;
  logic [OQ_CNT_W-1:0]   oq_cnt_r, oq_cnt_nxt;
  logic [OQ_CNT_W:0]     oq_claim;
  logic                  oq_push;
  logic                  oq_pop;

  // ---------------------------------------------------------------- input side
  assign oq_claim  = {1'b0, oq_cnt_r} + (OQ_CNT_W + 1)'(s1_valid_r);
  assign in_ready  = oq_claim < (OQ_CNT_W + 1)'(OQ_DEPTH);

  assign byte_beat = in_valid && in_ready && (in_data.req_type == REQ_BYTE);
  assign rd_beat   = in_valid && in_ready && (in_data.req_type == REQ_READ);

  assign wr_idx    = fill_r[IDX_W-1:0];
  assign in_frame  = fill_r < FILL_W'(FRAME_BYTES);
  assign not_full  = fill_r != FILL_W'(BUFFER_DEPTH);
  assign ram_we    = byte_beat && in_frame;

  // a position shared with the latched frame is written into the other bank
  always_comb begin
    wr_bank = 1'b0;
    if (in_frame) begin
      wr_bank = (rx_sel_r[wr_idx] == frame_sel_r[wr_idx]) ? ~rx_sel_r[wr_idx]
                                                          : rx_sel_r[wr_idx];
    end
  end

  assign sync_hit = byte_beat && (fill_r != '0) && (last_r == SYNC_PREV) &&
                    (in_data.rx_byte == SYNC_HEAD);

  always_comb begin
    fill_nxt      = fill_r;
    wr_res_nxt    = wr_res_r;
    wr_slot_nxt   = wr_slot_r;
    last_nxt      = last_r;
    rx_sel_nxt    = rx_sel_r;
    frame_sel_nxt = frame_sel_r;
    vld_nxt       = vld_r;
    if (ram_we) begin
      rx_sel_nxt[wr_idx]       = wr_bank;
      vld_nxt[wr_bank][wr_idx] = 1'b1;
      if (wr_res_r == RES_W'(RES_COUNT - 1)) begin
        wr_res_nxt  = '0;
        wr_slot_nxt = wr_slot_r + SLOT_W'(1);
      end else begin
        wr_res_nxt  = wr_res_r + RES_W'(1);
      end
    end
    if (byte_beat && not_full) begin
      fill_nxt = fill_r + FILL_W'(1);
      last_nxt = in_data.rx_byte;
    end
    if (sync_hit) begin
      // buffer restarts as if holding only the header at position 0
      fill_nxt      = FILL_W'(1);
      wr_res_nxt    = RES_W'(1);
      wr_slot_nxt   = '0;
      last_nxt      = SYNC_HEAD;
      frame_sel_nxt = rx_sel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      wr_res_r    <= '0;
      wr_slot_r   <= '0;
      last_r      <= '0;
      rx_sel_r    <= '0;
      frame_sel_r <= '0;
      vld_r       <= '0;
    end else begin
      fill_r      <= fill_nxt;
      wr_res_r    <= wr_res_nxt;
      wr_slot_r   <= wr_slot_nxt;
      last_r      <= last_nxt;
      rx_sel_r    <= rx_sel_nxt;
      frame_sel_r <= frame_sel_nxt;
      vld_r       <= vld_nxt;
    end
  end

  // ------------------------------------------------------------ read address
  assign loc = CHAN_LOC[in_data.channel_index];

  always_comb begin
    for (int k = 0; k < RES_COUNT; k++) begin
      rsum[k]   = {1'b0, loc.res} + (RES_W + 1)'(k);
      rd_idx[k] = loc.start + IDX_W'(k);
      if (rsum[k] >= (RES_W + 1)'(RES_COUNT)) begin
        rd_res[k]   = RES_W'(rsum[k] - (RES_W + 1)'(RES_COUNT));
        rd_kslot[k] = loc.slot + SLOT_W'(1);
      end else begin
        rd_res[k]   = rsum[k][RES_W-1:0];
        rd_kslot[k] = loc.slot;
      end
      // the byte past the frame end reads as zero
      if (rd_idx[k] >= IDX_W'(FRAME_BYTES)) begin
        rd_bank[k] = 1'b0;
        rd_zero[k] = 1'b1;
      end else begin
        rd_bank[k] = frame_sel_r[rd_idx[k]];
        rd_zero[k] = !vld_r[frame_sel_r[rd_idx[k]]][rd_idx[k]];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < RES_COUNT; r++) begin
      rd_slot[r] = '0;
      for (int k = 0; k < RES_COUNT; k++) begin
        if (rd_res[k] == RES_W'(r)) begin
          rd_slot[r] = rd_kslot[k];
        end
      end
    end
  end

  // ------------------------------------------------------------------- rams
  for (genvar b = 0; b < NBANK; b++) begin : g_bank
    for (genvar r = 0; r < RES_COUNT; r++) begin : g_res
      sfr_ram #(
        .WIDTH (BYTE_BITS),
        .DEPTH (SLOT_COUNT)
      ) u_ram (
        .clk   (clk),
        .we    (ram_we && (wr_bank == 1'(b)) && (wr_res_r == RES_W'(r))),
        .waddr (wr_slot_r),
        .wdata (in_data.rx_byte),
        .re    (rd_beat),
        .raddr (rd_slot[r]),
        .rdata (ram_rdata[b][r])
      );
    end
  end

  // ------------------------------------------------------------- read stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= rd_beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_beat) begin
      s1_ch_r    <= in_data.channel_index;
      s1_shift_r <= loc.shift;
      for (int k = 0; k < RES_COUNT; k++) begin
        s1_bank_r[k] <= rd_bank[k];
        s1_res_r[k]  <= rd_res[k];
        s1_zero_r[k] <= rd_zero[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < RES_COUNT; k++) begin
      s1_byte[k] = s1_zero_r[k] ? '0 : ram_rdata[s1_bank_r[k]][s1_res_r[k]];
    end
    s1_word                = {s1_byte[2], s1_byte[1], s1_byte[0]};
    s1_shifted             = s1_word >> s1_shift_r;
    s1_item.channel_value  = s1_shifted[CH_BITS-1:0];
    s1_item.channel_echo   = s1_ch_r;
  end

  // ----------------------------------------------------------- output queue
  assign oq_push   = s1_valid_r;
  assign out_valid = oq_cnt_r != '0;
  assign oq_pop    = out_valid && out_ready;
  assign out_data  = oq_mem_r[oq_head_r];

  always_comb begin
    oq_head_nxt = oq_head_r;
    oq_tail_nxt = oq_tail_r;
    oq_cnt_nxt  = oq_cnt_r;
    if (oq_push) begin
      oq_tail_nxt = (oq_tail_r == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0
                                                           : oq_tail_r + OQ_PTR_W'(1);
    end
    if (oq_pop) begin
      oq_head_nxt = (oq_head_r == OQ_PTR_W'(OQ_DEPTH - 1)) ? '0
                                                           : oq_head_r + OQ_PTR_W'(1);
    end
    if (oq_push && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + OQ_CNT_W'(1);
    end else if (oq_pop && !oq_push) begin
      oq_cnt_nxt = oq_cnt_r - OQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_head_r <= '0;
      oq_tail_r <= '0;
      oq_cnt_r  <= '0;
    end else begin
      oq_head_r <= oq_head_nxt;
      oq_tail_r <= oq_tail_nxt;
      oq_cnt_r  <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_mem_r[oq_tail_r] <= s1_item;
    end
  end

endmodule

// ===== hw/rtl/sfr_checker.sv =====
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the sbus frame receiver: result timing, ordering and
// output hold behavior.
// ----------------------------------------------------------------------------
module sfr_checker
  import sfr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  logic rd_beat;

  assign rd_beat = in_valid && in_ready && (in_data.req_type == REQ_READ);

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed or dropped");

  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    rd_beat |-> ##2 out_valid)
    else $error("read beat gave no result two cycles later");

  a_read_echo: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_beat && !out_valid) ##1 !out_valid |->
      ##1 (out_valid && out_data.channel_echo == $past(in_data.channel_index, 2)))
    else $error("result echo does not match the read beat");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(rd_beat, 2))
    else $error("result appeared without a read beat");

endmodule

bind sbus_frame_receiver_unit sfr_checker u_sfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
